@@ hdl/pcpf_pkg.sv @@
// Shared types, codes and character helpers for the pixel command parser.
// Used by every module of the block; depends on nothing.
package pcpf_pkg;

	localparam int DIM_W = 13;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_P   = "P";
	localparam logic [7:0] CH_X   = "X";
	localparam logic [7:0] CH_0   = "0";
	localparam logic [7:0] CH_9   = "9";

	localparam logic [2:0] KIND_SILENT = 3'd0;
	localparam logic [2:0] KIND_PIXEL  = 3'd1;
	localparam logic [2:0] KIND_SIZE   = 3'd2;
	localparam logic [2:0] KIND_STATS  = 3'd3;
	localparam logic [2:0] KIND_HELP   = 3'd4;
	localparam logic [2:0] KIND_ERROR  = 3'd5;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BAD_X   = 3'd1;
	localparam logic [2:0] ERR_NO_Y    = 3'd2;
	localparam logic [2:0] ERR_BAD_Y   = 3'd3;
	localparam logic [2:0] ERR_BAD_COL = 3'd4;
	localparam logic [2:0] ERR_COL_LEN = 3'd5;
	localparam logic [2:0] ERR_UNKNOWN = 3'd6;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0]  stream_byte;
		logic [15:0] connection_count;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  reply_kind;
		logic [2:0]  error_code;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] pixels_drawn;
		logic [15:0] clients_seen;
		logic        wrote_pixel;
	} rsp_t;

	typedef enum logic [2:0] {
		PH_HEAD, PH_X, PH_Y, PH_HEX, PH_HEXDONE, PH_DECIDED
	} phase_t;

	typedef enum logic [1:0] {OP_REPLY, OP_READ, OP_DRAW} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  kind;
		logic [2:0]  err;
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic [15:0] conn;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef enum logic [2:0] {
		BK_CLEAR, BK_IDLE, BK_ADDR, BK_READ, BK_MUL, BK_DONE
	} back_state_t;

	function automatic logic [7:0] word_char(logic [1:0] k, logic [2:0] p);
		logic [39:0] txt;
		logic [7:0]  c;
		case (k)
			2'd0: txt = {"SIZE", 8'h00};
			2'd1: txt = "STATS";
			2'd2: txt = {"HELP", 8'h00};
			default: txt = '0;
		endcase
		c = 8'h00;
		if (p < 3'd5) begin
			c = txt[39 - 8 * int'(p) -: 8];
		end
		return c;
	endfunction

	function automatic logic [2:0] word_len(logic [1:0] k);
		logic [2:0] l;
		case (k)
			2'd1: l = 3'd5;
			default: l = 3'd4;
		endcase
		return l;
	endfunction

	function automatic logic [2:0] word_kind(logic [1:0] k);
		logic [2:0] r;
		case (k)
			2'd0: r = KIND_SIZE;
			2'd1: r = KIND_STATS;
			default: r = KIND_HELP;
		endcase
		return r;
	endfunction

	// {valid, value} of a hex digit character
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end
		return r;
	endfunction

endpackage

@@ hdl/pcpf_front.sv @@
// Byte parser: tracks one text line and emits a classified job at newline.
// Depends on pcpf_pkg.
module pcpf_front
	import pcpf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  cmd_t cmd,
	output logic push,
	output job_t job
);

	phase_t      phase_q, phase_n;
	logic [3:0]  prefix_q, prefix_n;
	logic [2:0]  hcnt_q, hcnt_n;
	logic [31:0] x_q, x_n, y_q, y_n, hex_q, hex_n;
	logic [3:0]  tally_q, tally_n;
	logic [2:0]  dkind_q, dkind_n, derr_q, derr_n;
	logic        ended_q, ended_n;

	logic [7:0]  b;
	logic        is_dig;
	logic [3:0]  dval;
	logic [4:0]  hx;

	assign b      = cmd.stream_byte;
	assign is_dig = (b >= CH_0) && (b <= CH_9);
	assign dval   = 4'(b - CH_0);
	assign hx     = hex_digit(b);

	always_comb begin
		logic [3:0] pfx;
		logic       done;
		phase_n  = phase_q;
		prefix_n = prefix_q;
		hcnt_n   = hcnt_q;
		x_n      = x_q;
		y_n      = y_q;
		hex_n    = hex_q;
		tally_n  = tally_q;
		dkind_n  = dkind_q;
		derr_n   = derr_q;
		ended_n  = ended_q;
		pfx      = prefix_q;
		done     = 1'b0;
		if (take) begin
			if (b == CH_NL) begin
				phase_n  = PH_HEAD;
				prefix_n = 4'hF;
				hcnt_n   = '0;
				x_n      = '0;
				y_n      = '0;
				hex_n    = '0;
				tally_n  = '0;
				dkind_n  = KIND_SILENT;
				derr_n   = ERR_NONE;
				ended_n  = 1'b0;
			end else if (!ended_q) begin
				if (b == CH_NUL) begin
					ended_n = 1'b1;
				end else begin
					case (phase_q)
						PH_HEAD: begin
							if (pfx[0] && hcnt_q == 3'd2) begin
								phase_n = PH_X;
								tally_n = '0;
							end else begin
								if (pfx[0] && ((hcnt_q == 3'd0 && b != CH_P) ||
										(hcnt_q == 3'd1 && b != CH_X)))
									pfx[0] = 1'b0;
								for (int k = 0; k < 3; k++) begin
									if (pfx[k+1] && !done) begin
										if (hcnt_q >= word_len(2'(k)) ||
												b != word_char(2'(k), hcnt_q)) begin
											pfx[k+1] = 1'b0;
										end else if ((4'(hcnt_q) + 4'd1) ==
												4'(word_len(2'(k)))) begin
											phase_n = PH_DECIDED;
											dkind_n = word_kind(2'(k));
											derr_n  = ERR_NONE;
											done    = 1'b1;
										end
									end
								end
								prefix_n = pfx;
								if (!done && hcnt_q < 3'd7)
									hcnt_n = hcnt_q + 3'd1;
							end
						end
						PH_X: begin
							if (is_dig) begin
								x_n     = (x_q << 3) + (x_q << 1) + 32'(dval);
								tally_n = 4'd1;
							end else if (tally_q == '0) begin
								phase_n = PH_DECIDED;
								dkind_n = KIND_ERROR;
								derr_n  = ERR_BAD_X;
							end else begin
								phase_n = PH_Y;
								tally_n = '0;
							end
						end
						PH_Y: begin
							if (is_dig) begin
								y_n     = (y_q << 3) + (y_q << 1) + 32'(dval);
								tally_n = 4'd1;
							end else if (tally_q == '0) begin
								phase_n = PH_DECIDED;
								dkind_n = KIND_ERROR;
								derr_n  = ERR_BAD_Y;
							end else begin
								phase_n = PH_HEX;
								tally_n = '0;
							end
						end
						PH_HEX: begin
							if (hx[4]) begin
								hex_n = {hex_q[27:0], hx[3:0]};
								if (tally_q < 4'd15)
									tally_n = tally_q + 4'd1;
							end else if (tally_q == '0) begin
								phase_n = PH_DECIDED;
								dkind_n = KIND_ERROR;
								derr_n  = ERR_BAD_COL;
							end else begin
								phase_n = PH_HEXDONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// classify the line as it stands when the newline arrives
	always_comb begin
		job      = '0;
		job.op   = OP_REPLY;
		job.conn = cmd.connection_count;
		case (phase_q)
			PH_HEAD: begin
				if (hcnt_q >= 3'd2) begin
					job.kind = KIND_ERROR;
					job.err  = ERR_UNKNOWN;
				end
			end
			PH_X: begin
				job.kind = KIND_ERROR;
				job.err  = (tally_q != '0) ? ERR_NO_Y : ERR_BAD_X;
			end
			PH_Y: begin
				if (tally_q == '0) begin
					job.kind = KIND_ERROR;
					job.err  = ERR_BAD_Y;
				end else begin
					job.op   = OP_READ;
					job.kind = KIND_PIXEL;
					job.x    = x_q;
					job.y    = y_q;
				end
			end
			PH_HEX, PH_HEXDONE: begin
				if (tally_q == '0) begin
					job.kind = KIND_ERROR;
					job.err  = ERR_BAD_COL;
				end else if (tally_q == 4'd6 || tally_q == 4'd8 || tally_q == 4'd2) begin
					job.x = x_q;
					job.y = y_q;
					job.a = 8'd255;
					if (tally_q == 4'd6) begin
						job.r = hex_q[23:16];
						job.g = hex_q[15:8];
						job.b = hex_q[7:0];
					end else if (tally_q == 4'd8) begin
						job.r = hex_q[31:24];
						job.g = hex_q[23:16];
						job.b = hex_q[15:8];
						job.a = hex_q[7:0];
					end else begin
						job.r = hex_q[7:0];
						job.g = hex_q[7:0];
						job.b = hex_q[7:0];
					end
					// alpha zero: silent, nothing drawn or counted
					job.op = (job.a == 8'd0) ? OP_REPLY : OP_DRAW;
				end else begin
					job.kind = KIND_ERROR;
					job.err  = ERR_COL_LEN;
				end
			end
			default: begin
				job.kind = dkind_q;
				job.err  = derr_q;
			end
		endcase
	end

	assign push = take && (b == CH_NL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			prefix_q <= 4'hF;
			hcnt_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			hex_q    <= '0;
			tally_q  <= '0;
			dkind_q  <= KIND_SILENT;
			derr_q   <= ERR_NONE;
			ended_q  <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			prefix_q <= prefix_n;
			hcnt_q   <= hcnt_n;
			x_q      <= x_n;
			y_q      <= y_n;
			hex_q    <= hex_n;
			tally_q  <= tally_n;
			dkind_q  <= dkind_n;
			derr_q   <= derr_n;
			ended_q  <= ended_n;
		end
	end

endmodule

@@ hdl/pcpf_queue.sv @@
// Four-entry job queue between the parser and the executor.
// Depends on pcpf_pkg.
module pcpf_queue
	import pcpf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	input  logic   pop,
	output job_t   head,
	output qstat_t stat
);

	job_t       slot_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign stat.empty = (cnt_q == 3'd0);
	assign stat.full  = (cnt_q == 3'd4);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

@@ hdl/pcpf_back.sv @@
// Job executor: framebuffer memory, blending, draw counter, result register.
// Depends on pcpf_pkg.
module pcpf_back
	import pcpf_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	input  job_t             head,
	input  qstat_t           qstat,
	output logic             pop,
	output logic             clearing,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [7:0] div255(logic [15:0] v);
		logic [16:0] s;
		s = 17'(v) + 17'd1 + 17'(v[15:8]);
		return s[15:8];
	endfunction

	back_state_t state_q, state_n;
	job_t        job_q;
	logic        inb_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [23:0] rd_q;
	logic [23:0] fb [DEPTH];
	logic [15:0] po_r_q, po_g_q, po_b_q, pn_r_q, pn_g_q, pn_b_q;
	logic [31:0] cnt_q;
	rsp_t        out_q, res;
	logic        out_valid_q;

	logic          out_free, load, we, take_job;
	logic [AW-1:0] wa;
	logic [23:0]   wd;
	logic [7:0]    bl_r, bl_g, bl_b;
	logic [2*DIM_W-1:0] prod;
	logic [7:0]    inv_a;

	assign out_free = !out_valid_q || !rsp_stall;
	assign clearing = (state_q == BK_CLEAR);
	assign prod     = job_q.y[DIM_W-1:0] * width;
	assign inv_a    = 8'd255 - job_q.a;
	assign bl_r     = div255(po_r_q + pn_r_q);
	assign bl_g     = div255(po_g_q + pn_g_q);
	assign bl_b     = div255(po_b_q + pn_b_q);

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_n = BK_IDLE;
			BK_IDLE:  if (take_job) state_n = BK_ADDR;
			BK_ADDR:  state_n = BK_READ;
			BK_READ:  state_n = BK_MUL;
			BK_MUL:   state_n = BK_DONE;
			BK_DONE:  if (out_free) state_n = BK_IDLE;
			default:  state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		take_job = 1'b0;
		load     = 1'b0;
		we       = 1'b0;
		wa       = clr_q;
		wd       = '0;
		res      = '0;
		case (state_q)
			BK_CLEAR: we = 1'b1;
			BK_IDLE: begin
				res.reply_kind   = head.kind;
				res.error_code   = head.err;
				res.coord_x      = head.x;
				res.coord_y      = head.y;
				res.red          = head.r;
				res.green        = head.g;
				res.blue         = head.b;
				res.pixels_drawn = cnt_q;
				res.clients_seen = head.conn;
				if (head.kind == KIND_SIZE) begin
					res.coord_x = 32'(width);
					res.coord_y = 32'(height);
				end
				if (!qstat.empty) begin
					if (head.op == OP_REPLY) begin
						pop  = out_free;
						load = out_free;
					end else begin
						pop      = 1'b1;
						take_job = 1'b1;
					end
				end
			end
			BK_DONE: begin
				res.reply_kind   = job_q.kind;
				res.coord_x      = job_q.x;
				res.coord_y      = job_q.y;
				res.clients_seen = job_q.conn;
				res.pixels_drawn = cnt_q;
				load = out_free;
				if (job_q.op == OP_READ) begin
					if (inb_q) begin
						res.red   = rd_q[23:16];
						res.green = rd_q[15:8];
						res.blue  = rd_q[7:0];
					end
				end else begin
					res.pixels_drawn = cnt_q + 32'd1;
					res.red   = job_q.r;
					res.green = job_q.g;
					res.blue  = job_q.b;
					if (inb_q && job_q.a != 8'd255) begin
						res.red   = bl_r;
						res.green = bl_g;
						res.blue  = bl_b;
					end
					res.wrote_pixel = inb_q;
					we = out_free && inb_q;
					wa = addr_q;
					wd = {res.red, res.green, res.blue};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			fb[wa] <= wd;
		rd_q <= fb[addr_q];
	end

	always_ff @(posedge clk) begin
		if (take_job)
			job_q <= head;
		if (state_q == BK_ADDR) begin
			inb_q  <= (job_q.x < 32'(width)) && (job_q.y < 32'(height));
			addr_q <= AW'((2*DIM_W)'(job_q.x[DIM_W-1:0]) + prod);
		end
		if (state_q == BK_MUL) begin
			po_r_q <= rd_q[23:16] * inv_a;
			po_g_q <= rd_q[15:8] * inv_a;
			po_b_q <= rd_q[7:0] * inv_a;
			pn_r_q <= job_q.r * job_q.a;
			pn_g_q <= job_q.g * job_q.a;
			pn_b_q <= job_q.b * job_q.a;
		end
		if (load)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (load && state_q == BK_DONE && job_q.op == OP_DRAW)
				cnt_q <= cnt_q + 32'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ hdl/pixel_command_parser_framebuffer.sv @@
// Top level of the pixel command parser with framebuffer.
// Depends on pcpf_pkg, pcpf_front, pcpf_queue and pcpf_back.
//
// Usage:
//  - cmd channel: one command text byte per transfer (cmd_valid / cmd_stall).
//    Byte 10 ends a line; each line yields exactly one rsp transfer.
//  - rsp channel: one result per line (rsp_valid / rsp_stall), held while
//    stalled.
//  - APB port: canvas_width at 0x0, canvas_height at 0x4; write only while
//    idle. Widths above MAX_WIDTH / MAX_HEIGHT clamp to those limits.
// Throughput: one byte per cycle while cmd_stall is low. A silent, size,
// stats, help or error line goes from the job queue to the result
// register; a pixel read or draw steps through address multiply, memory
// read, blend multiply and write, shorter than any pixel line, so a
// 4-entry job queue absorbs the gap. Reset: the framebuffer is cleared
// one pixel per cycle over all MAX_WIDTH * MAX_HEIGHT pixels; cmd_stall
// stays high until the sweep finishes. When rsp_stall holds, the queue
// fills and cmd_stall rises; no byte is dropped.
module pixel_command_parser_framebuffer
	import pcpf_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [8:0]       width_q, height_q;
	logic [DIM_W-1:0] width_c, height_c;
	logic             take, push, pop, clearing;
	job_t             push_job, head;
	qstat_t           qstat;

	// configuration registers; writes complete in the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH)
				width_q <= pwdata[8:0];
			else
				height_q <= pwdata[8:0];
		end
	end
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	// clamp the canvas to the framebuffer's dimensions
	assign width_c  = (32'(width_q) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
	assign height_c = (32'(height_q) > 32'(MAX_HEIGHT)) ?
		DIM_W'(MAX_HEIGHT) : DIM_W'(height_q);

	// hold off bytes while the queue is full or the framebuffer is clearing
	assign cmd_stall = qstat.full || clearing;
	assign take      = cmd_valid && !cmd_stall;

	pcpf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cmd    (cmd),
		.push   (push),
		.job    (push_job)
	);

	pcpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	pcpf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (width_c),
		.height    (height_c),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ tb/pixel_command_parser_framebuffer_test.sv @@
// Testbench for the pixel command parser with framebuffer: drives command text,
// predicts every line's reply with an in-bench model of the parser and canvas.
// Depends on pcpf_pkg and the pixel_command_parser_framebuffer RTL.
`timescale 1ns / 1ps

module pixel_command_parser_framebuffer_test;
	import pcpf_pkg::*;

	localparam int CANVAS_MAX = 256;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pixel_command_parser_framebuffer u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: canvas, line parser and draw counter.
	logic [23:0] canvas_mem [CANVAS_MAX*CANVAS_MAX];
	logic [8:0]  width_reg, height_reg;
	phase_t      line_phase;
	logic [3:0]  word_live;
	logic [31:0] x_val, y_val, hex_val, drawn_total;
	logic [3:0]  digit_cnt;
	logic [2:0]  head_pos;
	logic [2:0]  held_kind, held_err;
	logic        nul_seen;

	cmd_t  byte_queue[$];
	rsp_t  reply_queue[$];
	int    sender_idle_pct, receiver_idle_pct;
	int    hold_cycles;
	int    mismatches;
	int    lines_sent;
	bit    flow_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void start_line();
		line_phase = PH_HEAD;
		word_live  = 4'hF;
		x_val = '0; y_val = '0; hex_val = '0;
		digit_cnt = '0; head_pos = '0;
		held_kind = KIND_SILENT; held_err = ERR_NONE;
		nul_seen = 1'b0;
	endfunction

	function automatic logic [4:0] hex_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic logic [7:0] mix_channel(logic [7:0] prev, logic [7:0] fresh,
			logic [7:0] alpha);
		return 8'(({24'd0, prev} * (32'd255 - alpha) + {24'd0, fresh} * alpha) / 32'd255);
	endfunction

	// Advance the line parser by one non-newline byte.
	function automatic void parse_byte(logic [7:0] c);
		string kw [3];
		logic [2:0] kw_kind [3];
		logic [4:0] hv;
		logic [2:0] p;
		kw[0] = "SIZE"; kw[1] = "STATS"; kw[2] = "HELP";
		kw_kind[0] = KIND_SIZE; kw_kind[1] = KIND_STATS; kw_kind[2] = KIND_HELP;
		p = head_pos;
		if (nul_seen) return;
		if (c == CH_NUL) begin
			nul_seen = 1'b1;
			return;
		end
		case (line_phase)
			PH_HEAD: begin
				if (word_live[0]) begin
					if (p == 3'd2) begin
						line_phase = PH_X;
						digit_cnt = '0;
						return;
					end
					if ((p == 3'd0 && c != CH_P) || (p == 3'd1 && c != CH_X))
						word_live[0] = 1'b0;
				end
				for (int k = 0; k < 3; k++) begin
					if (!word_live[k+1]) continue;
					if (p >= kw[k].len() || c != kw[k][p]) begin
						word_live[k+1] = 1'b0;
					end else if (p + 1 == kw[k].len()) begin
						line_phase = PH_DECIDED;
						held_kind = kw_kind[k];
						held_err = ERR_NONE;
						return;
					end
				end
				if (head_pos < 3'd7) head_pos++;
			end
			PH_X, PH_Y: begin
				if (c >= CH_0 && c <= CH_9) begin
					if (line_phase == PH_X) x_val = x_val * 10 + 32'(c - CH_0);
					else y_val = y_val * 10 + 32'(c - CH_0);
					digit_cnt = 4'd1;
				end else if (digit_cnt == 0) begin
					held_err = (line_phase == PH_X) ? ERR_BAD_X : ERR_BAD_Y;
					held_kind = KIND_ERROR;
					line_phase = PH_DECIDED;
				end else begin
					line_phase = (line_phase == PH_X) ? PH_Y : PH_HEX;
					digit_cnt = '0;
				end
			end
			PH_HEX: begin
				hv = hex_of(c);
				if (hv[4]) begin
					hex_val = {hex_val[27:0], hv[3:0]};
					if (digit_cnt < 4'd15) digit_cnt++;
				end else if (digit_cnt == 0) begin
					line_phase = PH_DECIDED;
					held_kind = KIND_ERROR;
					held_err = ERR_BAD_COL;
				end else begin
					line_phase = PH_HEXDONE;
				end
			end
			default: ;
		endcase
	endfunction

	// Work out the reply of a line ended by a newline and update the canvas.
	function automatic rsp_t finish_line(logic [15:0] conn);
		rsp_t   o;
		int     w, h, idx;
		bit     inb, skip;
		logic [7:0]  alpha;
		logic [23:0] prev;
		o = '0;
		w = (width_reg > CANVAS_MAX) ? CANVAS_MAX : width_reg;
		h = (height_reg > CANVAS_MAX) ? CANVAS_MAX : height_reg;
		inb = (x_val < w) && (y_val < h);
		idx = inb ? int'(x_val) + int'(y_val) * w : 0;
		case (line_phase)
			PH_HEAD: if (head_pos >= 2) begin
				o.reply_kind = KIND_ERROR; o.error_code = ERR_UNKNOWN;
			end
			PH_X: begin
				o.reply_kind = KIND_ERROR;
				o.error_code = digit_cnt != 0 ? ERR_NO_Y : ERR_BAD_X;
			end
			PH_Y: begin
				if (digit_cnt == 0) begin
					o.reply_kind = KIND_ERROR; o.error_code = ERR_BAD_Y;
				end else begin
					o.reply_kind = KIND_PIXEL; o.coord_x = x_val; o.coord_y = y_val;
					if (inb) {o.red, o.green, o.blue} = canvas_mem[idx];
				end
			end
			PH_HEX, PH_HEXDONE: begin
				alpha = 8'd255;
				skip = 1'b0;
				if (digit_cnt == 6) begin
					{o.red, o.green, o.blue} = hex_val[23:0];
				end else if (digit_cnt == 8) begin
					{o.red, o.green, o.blue, alpha} = hex_val;
				end else if (digit_cnt == 2) begin
					o.red = hex_val[7:0]; o.green = hex_val[7:0]; o.blue = hex_val[7:0];
				end else begin
					o.reply_kind = KIND_ERROR;
					o.error_code = digit_cnt == 0 ? ERR_BAD_COL : ERR_COL_LEN;
					skip = 1'b1;
				end
				if (!skip) begin
					o.coord_x = x_val; o.coord_y = y_val;
					if (alpha != 0) begin
						drawn_total++;
						if (inb) begin
							if (alpha != 8'd255) begin
								prev = canvas_mem[idx];
								o.red   = mix_channel(prev[23:16], o.red, alpha);
								o.green = mix_channel(prev[15:8], o.green, alpha);
								o.blue  = mix_channel(prev[7:0], o.blue, alpha);
							end
							canvas_mem[idx] = {o.red, o.green, o.blue};
							o.wrote_pixel = 1'b1;
						end
					end
				end
			end
			default: begin
				o.reply_kind = held_kind; o.error_code = held_err;
				if (held_kind == KIND_SIZE) begin
					o.coord_x = w; o.coord_y = h;
				end
			end
		endcase
		o.pixels_drawn = drawn_total;
		o.clients_seen = conn;
		start_line();
		return o;
	endfunction

	// Queue one byte for the sender.
	task automatic push_byte(logic [7:0] c);
		cmd_t t;
		t.stream_byte = c;
		t.connection_count = 16'($urandom);
		byte_queue.push_back(t);
		if (c == CH_NL) lines_sent++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
		push_byte(CH_NL);
	endtask

	function automatic string rand_hex(int n);
		string s, digs;
		digs = "0123456789abcdefABCDEF";
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(digs[$urandom_range(21, 0)])};
		return s;
	endfunction

	// Well-formed pixel lines mostly, with some keyword, noise and broken lines.
	task automatic push_random_line();
		int pick, xr, yr;
		string s;
		int lens [4];
		lens[0] = 2; lens[1] = 6; lens[2] = 8; lens[3] = $urandom_range(9, 1);
		pick = $urandom_range(99, 0);
		xr = ($urandom_range(9, 0) == 0) ? $urandom_range(400, 0) : $urandom_range(20, 0);
		yr = ($urandom_range(9, 0) == 0) ? $urandom_range(400, 0) : $urandom_range(20, 0);
		if (pick < 40) begin
			s = $sformatf("PX %0d %0d %s", xr, yr, rand_hex(lens[$urandom_range(3, 0)]));
			if (lens[2] == 8 && $urandom_range(5, 0) == 0) s = {s, "00"};
			push_text(s);
		end else if (pick < 60) begin
			push_text($sformatf("PX %0d %0d", xr, yr));
		end else if (pick < 68) begin
			case ($urandom_range(2, 0))
				0: push_text("SIZE");
				1: push_text("STATS");
				default: push_text("HELP");
			endcase
		end else if (pick < 78) begin
			// Broken pixel lines: bad separators and stray bytes.
			s = $sformatf("PX%s%0d%s%0d", $urandom_range(1, 0) ? " " : "",
				xr, $urandom_range(1, 0) ? " " : "zz", yr);
			push_text(s);
		end else begin
			// Noise: random bytes, including NUL and high values.
			for (int i = $urandom_range(12, 0); i > 0; i--) begin
				do pick = $urandom_range(255, 0); while (pick == CH_NL);
				push_byte(8'(pick));
			end
			push_byte(CH_NL);
		end
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == 3'(REG_WIDTH) * 3'd4) width_reg = data[8:0];
		else height_reg = data[8:0];
	endtask

	// Wait for the queued stimulus to drain and every reply to arrive.
	task automatic drain();
		while (byte_queue.size() != 0 || reply_queue.size() != 0 || cmd_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Predict at acceptance so replies queue in line order.
	function automatic void reply_queue_hook(cmd_t t);
		if (t.stream_byte == CH_NL) reply_queue.push_back(finish_line(t.connection_count));
		else parse_byte(t.stream_byte);
	endfunction

	// Driver: present the head of the byte queue, advance on a transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				reply_queue_hook(cmd);
			end
			if (cmd_valid && cmd_stall) begin
				// hold the stalled transfer
			end else if (byte_queue.size() != 0 &&
					$urandom_range(99, 0) >= sender_idle_pct) begin
				cmd_valid <= 1'b1;
				cmd <= byte_queue.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random, or a long hold-off counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
		end
	end

	// Monitor: compare each reply transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (reply_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected reply %p", rsp);
			end else begin
				rsp_t e;
				e = reply_queue.pop_front();
				if (e !== rsp) begin
					mismatches++;
					if (mismatches <= 10) $display("reply mismatch\n  exp %p\n  got %p", e, rsp);
				end
			end
		end
	end

	initial begin
		#400ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		sender_idle_pct = 35; receiver_idle_pct = 74;
		hold_cycles = 0; mismatches = 0; lines_sent = 0;
		for (int i = 0; i < CANVAS_MAX*CANVAS_MAX; i++) canvas_mem[i] = '0;
		width_reg = 9'd256; height_reg = 9'd256; drawn_total = '0;
		start_line();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines: every reply kind, error code and colour form.
		push_text("PX 0 0");
		push_text("PX 0 0 ff");
		push_text("PX 255 255 123456");
		push_text("PX 255 255");
		push_text("PX 0 0 11223380");
		push_text("PX 0 0 aabbcc00");
		push_text("PX 4294967295 4294967296 ABCDEF");
		push_text("PX 1 1 fff");
		push_text("PX 1 1 0123456789abcdef0");
		push_text("PX 1 1 zz");
		push_text("PX a");
		push_text("PX 12");
		push_text("PX 12 q");
		push_text("SIZE"); push_text("STATS"); push_text("HELP");
		push_text("P"); push_text("");
		push_text("QQ");
		push_byte("S"); push_byte(CH_NUL); push_byte("Q"); push_byte("Q"); push_byte(CH_NL);
		push_byte(8'hFF); push_byte(8'h80); push_byte(CH_NL);
		drain();

		apb_write(3'd0, 32'd1);
		apb_write(3'd4, 32'd1);
		push_text("SIZE"); push_text("PX 0 0 7f"); push_text("PX 1 0 7f"); push_text("PX 0 0");
		drain();
		apb_write(3'd0, 32'h1FF);
		apb_write(3'd4, 32'd300);
		push_text("SIZE");
		drain();
		apb_write(3'd0, 32'd17);
		apb_write(3'd4, 32'd9);

		// Random phases with the three idle schemes.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				sender_idle_pct = 74; receiver_idle_pct = 35;
			end else if (ph == 2) begin
				sender_idle_pct = 0; receiver_idle_pct = 0;
				apb_write(3'd0, 32'd256);
				apb_write(3'd4, 32'd256);
			end
			repeat (10) push_random_line();
			if (ph == 0) hold_cycles = 400;
			repeat (10) push_random_line();
			drain();
		end

		if (mismatches == 0 && reply_queue.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
